>>> hw/rtl/mpkm_pkg.sv
// Shared types and constants for the multi-prefix key matcher.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none

package mpkm_pkg;

    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 4;
    localparam int KIND_W    = 2;
    localparam int OUT_CNT_W = 48;
    localparam int PCOUNT_W  = 5;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [KIND_W-1:0]   t_kind;

    localparam t_action ACT_SPEC  = 2'd0;
    localparam t_action ACT_KEY   = 2'd1;
    localparam t_action ACT_READ  = 2'd2;
    localparam t_action ACT_CLEAR = 2'd3;

    localparam t_kind KIND_KEY  = 2'd0;
    localparam t_kind KIND_READ = 2'd1;
    localparam t_kind KIND_SPEC = 2'd2;

    localparam logic [BYTE_W-1:0] SEP_BYTE = 8'd124;

endpackage

`default_nettype wire

>>> hw/rtl/mpkm_if.sv
// Valid/ready channel interfaces for the key matcher: command beats in, result beats out.
// Depends on mpkm_pkg for field widths.
`default_nettype none

interface mpkm_in_if;
    import mpkm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    logic [INDEX_W-1:0]  pattern_index;

    modport source (output valid, output action, output data_byte, output last,
                    output pattern_index, input ready);
    modport sink   (input valid, input action, input data_byte, input last,
                    input pattern_index, output ready);
endinterface

interface mpkm_out_if;
    import mpkm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic                 found;
    logic [OUT_CNT_W-1:0] hit_count;
    logic [OUT_CNT_W-1:0] miss_count;
    logic [PCOUNT_W-1:0]  prefix_count;
    logic                 dropped;

    modport source (output valid, output kind, output found, output hit_count,
                    output miss_count, output prefix_count, output dropped, input ready);
    modport sink   (input valid, input kind, input found, input hit_count,
                    input miss_count, input prefix_count, input dropped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mpkm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module mpkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/multi_prefix_key_matcher.sv
// Spec, read and non-final key beats pass through one working state; a clear is handled
// in the idle state; a final key beat with prefixes held walks the whole hit counter RAM,
// and skips the walk when the table is empty.
// One command beat is in flight at a time; a result waits in the output register meanwhile,
// and a new result stalls the block until the receiver takes the previous one.
// Reset is synchronous and active low; it empties the table and zeroes the miss counter.
`default_nettype none

module multi_prefix_key_matcher #(
    parameter int NUM_PREFIXES   = 16,
    parameter int MAX_PREFIX_LEN = 64,
    parameter int COUNTER_WIDTH  = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    mpkm_in_if.sink        i_in,
    mpkm_out_if.source     o_out
);
    import mpkm_pkg::*;

    localparam int LW    = $clog2(MAX_PREFIX_LEN + 1);
    localparam int RAW   = (MAX_PREFIX_LEN > 1) ? $clog2(MAX_PREFIX_LEN) : 1;
    localparam int TW    = $clog2(NUM_PREFIXES + 1);
    localparam int CAW   = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1;
    localparam int ROW_W = NUM_PREFIXES * BYTE_W;
    localparam int CW    = COUNTER_WIDTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SPEC = 3'd1;
    localparam logic [2:0] ST_KEY  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_KEND = 3'd4;
    localparam logic [2:0] ST_READ = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [TW-1:0]           r_total, n_total;
    logic [NUM_PREFIXES-1:0] r_alive, n_alive;
    logic [LW-1:0]           r_pos, n_pos;
    logic [LW-1:0]           r_load_len, n_load_len;
    logic                    r_too_long, n_too_long;
    logic                    r_drop, n_drop;
    logic [CW-1:0]           r_miss, n_miss;
    logic [NUM_PREFIXES-1:0] r_match, n_match;
    logic [TW-1:0]           r_walk, n_walk;
    logic                    r_pend, n_pend;
    logic [CAW-1:0]          r_pend_idx, n_pend_idx;
    logic                    r_default;

    logic [LW-1:0]           r_len [NUM_PREFIXES];
    logic [BYTE_W-1:0]       r_byte;
    logic                    r_last;
    logic [INDEX_W-1:0]      r_idx;

    logic                    r_out_valid;
    t_kind                   r_out_kind;
    logic                    r_out_found;
    logic [OUT_CNT_W-1:0]    r_out_hit;
    logic [OUT_CNT_W-1:0]    r_out_miss;
    logic [PCOUNT_W-1:0]     r_out_pcount;
    logic                    r_out_drop;

    logic                    row_we, row_re;
    logic [RAW-1:0]          row_waddr, row_raddr;
    logic [ROW_W-1:0]        row_wdata, row_rdata;
    logic                    cnt_we, cnt_re;
    logic [CAW-1:0]          cnt_waddr, cnt_raddr;
    logic [CW-1:0]           cnt_wdata, cnt_rdata;

    logic                    in_fire, out_free, proceed, emit;
    t_kind                   em_kind;
    logic                    em_found;
    logic [OUT_CNT_W-1:0]    em_hit;
    logic                    len_we;
    logic [LW-1:0]           take_len;
    logic [CAW-1:0]          col;
    logic [NUM_PREFIXES-1:0] alive_upd, held, fits;
    logic [LW-1:0]           pos_new;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign col      = r_total[CAW-1:0];

    mpkm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PREFIX_LEN)) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_we),
        .i_wr_addr (row_waddr),
        .i_wr_data (row_wdata),
        .i_rd_en   (row_re),
        .i_rd_addr (row_raddr),
        .o_rd_data (row_rdata)
    );

    mpkm_ram #(.WIDTH(CW), .DEPTH(NUM_PREFIXES)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (cnt_waddr),
        .i_wr_data (cnt_wdata),
        .i_rd_en   (cnt_re),
        .i_rd_addr (cnt_raddr),
        .o_rd_data (cnt_rdata)
    );

    always_comb begin
        for (int i = 0; i < NUM_PREFIXES; i++) begin
            held[i] = TW'(i) < r_total;
        end
        pos_new = (r_pos < LW'(MAX_PREFIX_LEN)) ? r_pos + LW'(1) : r_pos;
        for (int i = 0; i < NUM_PREFIXES; i++) begin
            alive_upd[i] = r_alive[i];
            if (r_alive[i] && held[i] && (r_pos < r_len[i]) && (r_pos < LW'(MAX_PREFIX_LEN))
                && (row_rdata[i*BYTE_W +: BYTE_W] != r_byte)) begin
                alive_upd[i] = 1'b0;
            end
            fits[i] = r_len[i] <= pos_new;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_alive    = r_alive;
        n_pos      = r_pos;
        n_load_len = r_load_len;
        n_too_long = r_too_long;
        n_drop     = r_drop;
        n_miss     = r_miss;
        n_match    = r_match;
        n_walk     = r_walk;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        i_in.ready = 1'b0;
        row_we     = 1'b0;
        row_re     = 1'b0;
        row_waddr  = r_load_len[RAW-1:0];
        row_raddr  = r_pos[RAW-1:0];
        row_wdata  = row_rdata;
        cnt_re     = 1'b0;
        cnt_raddr  = r_walk[CAW-1:0];
        cnt_we     = r_pend && r_match[r_pend_idx];
        cnt_waddr  = r_pend_idx;
        cnt_wdata  = cnt_rdata + CW'(1);
        emit       = 1'b0;
        proceed    = 1'b1;
        em_kind    = KIND_KEY;
        em_found   = 1'b0;
        em_hit     = '0;
        len_we     = 1'b0;
        take_len   = r_load_len;

        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (in_fire) begin
                    unique case (i_in.action)
                        ACT_SPEC: begin
                            row_raddr = r_load_len[RAW-1:0];
                            row_re    = (i_in.data_byte != SEP_BYTE)
                                        && (r_load_len < LW'(MAX_PREFIX_LEN))
                                        && (r_total < TW'(NUM_PREFIXES));
                            n_state   = ST_SPEC;
                        end
                        ACT_KEY: begin
                            row_re  = r_pos < LW'(MAX_PREFIX_LEN);
                            n_state = ST_KEY;
                        end
                        ACT_READ: begin
                            cnt_re    = 1'b1;
                            cnt_raddr = CAW'(i_in.pattern_index);
                            n_state   = ST_READ;
                        end
                        ACT_CLEAR: begin
                            n_total    = '0;
                            n_miss     = '0;
                            n_load_len = '0;
                            n_too_long = 1'b0;
                            n_drop     = 1'b0;
                            n_alive    = '1;
                            n_pos      = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SPEC: begin
                emit    = r_last;
                em_kind = KIND_SPEC;
                if (r_byte != SEP_BYTE) begin
                    if (r_load_len >= LW'(MAX_PREFIX_LEN)) begin
                        n_too_long = 1'b1;
                    end else begin
                        if (r_total < TW'(NUM_PREFIXES)) begin
                            row_we = 1'b1;
                            row_wdata[col*BYTE_W +: BYTE_W] = r_byte;
                        end
                        take_len   = r_load_len + LW'(1);
                        n_load_len = take_len;
                    end
                end
                if ((r_byte == SEP_BYTE) || r_last) begin
                    if (take_len != '0) begin
                        if (n_too_long || (r_total >= TW'(NUM_PREFIXES))) begin
                            n_drop = 1'b1;
                        end else begin
                            len_we       = 1'b1;
                            cnt_we       = 1'b1;
                            cnt_waddr    = col;
                            cnt_wdata    = '0;
                            n_alive[col] = r_pos == '0;
                            n_total      = r_total + TW'(1);
                        end
                    end
                    n_load_len = '0;
                    n_too_long = 1'b0;
                end
                n_state = ST_IDLE;
            end
            ST_KEY: begin
                n_alive = alive_upd;
                n_pos   = pos_new;
                n_state = ST_IDLE;
                if (r_last) begin
                    n_alive = '1;
                    n_pos   = '0;
                    if (r_total == '0) begin
                        emit     = 1'b1;
                        em_found = r_default;
                    end else begin
                        n_match = alive_upd & held & fits;
                        n_walk  = '0;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_walk < TW'(NUM_PREFIXES)) begin
                    cnt_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_walk[CAW-1:0];
                    n_walk     = r_walk + TW'(1);
                end else begin
                    n_state = ST_KEND;
                end
            end
            ST_KEND: begin
                emit     = 1'b1;
                em_found = |r_match;
                if (!(|r_match)) begin
                    n_miss = r_miss + CW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_READ: begin
                emit    = 1'b1;
                em_kind = KIND_READ;
                if (9'(r_idx) < 9'(r_total)) begin
                    em_hit = OUT_CNT_W'(cnt_rdata);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        proceed = !emit || out_free;
        if (!proceed) begin
            n_state    = r_state;
            n_total    = r_total;
            n_alive    = r_alive;
            n_pos      = r_pos;
            n_load_len = r_load_len;
            n_too_long = r_too_long;
            n_drop     = r_drop;
            n_miss     = r_miss;
            n_match    = r_match;
            row_we     = 1'b0;
            cnt_we     = 1'b0;
            len_we     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_alive     <= '1;
            r_pos       <= '0;
            r_load_len  <= '0;
            r_too_long  <= 1'b0;
            r_drop      <= 1'b0;
            r_miss      <= '0;
            r_match     <= '0;
            r_walk      <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_default   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_alive    <= n_alive;
            r_pos      <= n_pos;
            r_load_len <= n_load_len;
            r_too_long <= n_too_long;
            r_drop     <= n_drop;
            r_miss     <= n_miss;
            r_match    <= n_match;
            r_walk     <= n_walk;
            r_pend     <= n_pend;
            r_pend_idx <= n_pend_idx;
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
            if (emit && proceed) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last;
            r_idx  <= i_in.pattern_index;
        end
        if (len_we) begin
            r_len[col] <= take_len;
        end
        if (emit && proceed) begin
            r_out_kind   <= em_kind;
            r_out_found  <= em_found;
            r_out_hit    <= em_hit;
            r_out_miss   <= OUT_CNT_W'(n_miss);
            r_out_pcount <= PCOUNT_W'(n_total);
            r_out_drop   <= n_drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.found        = r_out_found;
    assign o_out.hit_count    = r_out_hit;
    assign o_out.miss_count   = r_out_miss;
    assign o_out.prefix_count = r_out_pcount;
    assign o_out.dropped      = r_out_drop;

endmodule

`default_nettype wire

>>> hw/rtl/mpkm_checker.sv
// Port-level assertions for the multi-prefix key matcher, attached by a bind.
// Depends on mpkm_pkg and the top level multi_prefix_key_matcher.
`default_nettype none

module mpkm_checker #(
    parameter int NUM_PREFIXES = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [mpkm_pkg::ACTION_W-1:0]   i_in_action,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mpkm_pkg::KIND_W-1:0]     i_out_kind,
    input logic                            i_out_found,
    input logic [mpkm_pkg::OUT_CNT_W-1:0]  i_out_hit_count,
    input logic [mpkm_pkg::OUT_CNT_W-1:0]  i_out_miss_count,
    input logic [mpkm_pkg::PCOUNT_W-1:0]   i_out_prefix_count
);
    import mpkm_pkg::*;

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_hit_count) && $stable(i_out_miss_count))
        else $error("result beat changed while stalled");

    // Every command beat other than a clear drops ready in the cycle after it is taken.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action != ACT_CLEAR) |=> !i_in_ready)
        else $error("command beat taken while previous one still in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_prefix_count) <= NUM_PREFIXES)
        else $error("prefix count beyond table size");

    a_found_only_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_KEY) |-> !i_out_found)
        else $error("found set on a non-key result");

    a_hit_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_READ) |-> i_out_hit_count == '0)
        else $error("hit count set on a non-read result");

endmodule

bind multi_prefix_key_matcher mpkm_checker #(.NUM_PREFIXES(NUM_PREFIXES)) u_mpkm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_action        (i_in.action),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_kind         (o_out.kind),
    .i_out_found        (o_out.found),
    .i_out_hit_count    (o_out.hit_count),
    .i_out_miss_count   (o_out.miss_count),
    .i_out_prefix_count (o_out.prefix_count)
);

`default_nettype wire

>>> tb/sv/multi_prefix_key_matcher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_prefix_key_matcher: prefix loading, key matching,
// counter reads and clears, checked beat by beat against a predictor kept in the bench.
// Depends on mpkm_pkg, the channel interfaces in mpkm_if and the matcher RTL.

module multi_prefix_key_matcher_tb;
    import mpkm_pkg::*;

    localparam int NUM_PREFIXES   = 16;
    localparam int MAX_PREFIX_LEN = 64;
    localparam int COUNTER_WIDTH  = 48;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 1000000;

    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B = 8'h62;
    localparam logic [BYTE_W-1:0] CH_C = 8'h63;

    typedef struct packed {
        t_kind                kind;
        logic                 found;
        logic [OUT_CNT_W-1:0] hit_count;
        logic [OUT_CNT_W-1:0] miss_count;
        logic [PCOUNT_W-1:0]  prefix_count;
        logic                 dropped;
    } t_match_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    mpkm_in_if  in_if ();
    mpkm_out_if out_if ();

    multi_prefix_key_matcher #(
        .NUM_PREFIXES   (NUM_PREFIXES),
        .MAX_PREFIX_LEN (MAX_PREFIX_LEN),
        .COUNTER_WIDTH  (COUNTER_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [BYTE_W-1:0]    tbl_bytes [NUM_PREFIXES][MAX_PREFIX_LEN];
    int                   tbl_len [NUM_PREFIXES];
    logic                 live [NUM_PREFIXES];
    logic [OUT_CNT_W-1:0] hits [NUM_PREFIXES];
    logic [OUT_CNT_W-1:0] misses;
    int                   tbl_count;
    int                   key_pos;
    int                   spec_len;
    logic                 spec_overflow;
    logic                 drop_seen;
    logic                 default_found;

    t_match_result        pending_results [$];
    logic [BYTE_W-1:0]    stream [$];
    int                   error_count;
    int                   items_sent;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_left;
    logic                 hold_req;
    logic                 hold_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [OUT_CNT_W-1:0] want,
                                        logic [OUT_CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_match_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, kind %0d", $time,
                         out_if.kind);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", OUT_CNT_W'(want.kind), OUT_CNT_W'(out_if.kind));
                check_field("found", OUT_CNT_W'(want.found), OUT_CNT_W'(out_if.found));
                check_field("hit_count", want.hit_count, out_if.hit_count);
                check_field("miss_count", want.miss_count, out_if.miss_count);
                check_field("prefix_count", OUT_CNT_W'(want.prefix_count),
                            OUT_CNT_W'(out_if.prefix_count));
                check_field("dropped", OUT_CNT_W'(want.dropped), OUT_CNT_W'(out_if.dropped));
            end
        end
    end

    function automatic void clear_table();
        int i;
        for (i = 0; i < NUM_PREFIXES; i++) begin
            tbl_len[i] = 0;
            hits[i]    = '0;
            live[i]    = 1'b1;
        end
        tbl_count     = 0;
        misses        = '0;
        key_pos       = 0;
        spec_len      = 0;
        spec_overflow = 1'b0;
        drop_seen     = 1'b0;
    endfunction

    function automatic void push_result(t_kind kind, logic found, logic [OUT_CNT_W-1:0] h);
        t_match_result r;
        r.kind         = kind;
        r.found        = found;
        r.hit_count    = h;
        r.miss_count   = misses;
        r.prefix_count = tbl_count[PCOUNT_W-1:0];
        r.dropped      = drop_seen;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_command(t_action act, logic [BYTE_W-1:0] b, logic last,
                                          logic [INDEX_W-1:0] idx);
        int   i;
        logic any;
        case (act)
            ACT_SPEC: begin
                if (b != SEP_BYTE) begin
                    if (spec_len >= MAX_PREFIX_LEN) begin
                        spec_overflow = 1'b1;
                    end else begin
                        if (tbl_count < NUM_PREFIXES) tbl_bytes[tbl_count][spec_len] = b;
                        spec_len++;
                    end
                end
                if (b == SEP_BYTE || last) begin
                    if (spec_len != 0) begin
                        if (spec_overflow || tbl_count >= NUM_PREFIXES) begin
                            drop_seen = 1'b1;
                        end else begin
                            tbl_len[tbl_count] = spec_len;
                            hits[tbl_count]    = '0;
                            live[tbl_count]    = (key_pos == 0);
                            tbl_count++;
                        end
                    end
                    spec_len      = 0;
                    spec_overflow = 1'b0;
                end
                if (last) push_result(KIND_SPEC, 1'b0, '0);
            end
            ACT_KEY: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (live[i] && key_pos < tbl_len[i] && tbl_bytes[i][key_pos] != b)
                        live[i] = 1'b0;
                end
                if (key_pos < MAX_PREFIX_LEN) key_pos++;
                if (last) begin
                    any = 1'b0;
                    if (tbl_count == 0) begin
                        any = default_found;
                    end else begin
                        for (i = 0; i < tbl_count; i++) begin
                            if (live[i] && tbl_len[i] <= key_pos) begin
                                hits[i] = hits[i] + 1'b1;
                                any     = 1'b1;
                            end
                        end
                        if (!any) misses = misses + 1'b1;
                    end
                    for (i = 0; i < NUM_PREFIXES; i++) live[i] = 1'b1;
                    key_pos = 0;
                    push_result(KIND_KEY, any, '0);
                end
            end
            ACT_READ: begin
                push_result(KIND_READ, 1'b0, (idx < tbl_count) ? hits[idx] : '0);
            end
            default: begin
                clear_table();
            end
        endcase
    endfunction

    task automatic send_beat(t_action act, logic [BYTE_W-1:0] b, logic last,
                             logic [INDEX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.action        <= act;
        in_if.data_byte     <= b;
        in_if.last          <= last;
        in_if.pattern_index <= idx;
        do @(posedge i_clk); while (!in_if.ready);
        apply_command(act, b, last, idx);
        items_sent++;
    endtask

    task automatic send_stream(t_action act);
        int i;
        for (i = 0; i < stream.size(); i++)
            send_beat(act, stream[i], (i == stream.size() - 1), INDEX_W'($urandom_range(15)));
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_default(logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        default_found = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0, 1:    return CH_A;
            2, 3:    return CH_B;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic test_empty_table_default();
        write_default(1'b1);
        send_beat(ACT_KEY, CH_A, 1'b1, 4'd0);
        wait_idle();
        write_default(1'b0);
        send_beat(ACT_KEY, 8'h00, 1'b1, 4'd15);
        send_beat(ACT_READ, 8'hFF, 1'b1, 4'd15);
        wait_idle();
    endtask

    task automatic test_load_and_match();
        send_beat(ACT_SPEC, 8'h00, 1'b0, 4'd0);
        send_beat(ACT_SPEC, CH_A, 1'b0, 4'd0);
        send_beat(ACT_SPEC, SEP_BYTE, 1'b0, 4'd0);
        send_beat(ACT_SPEC, SEP_BYTE, 1'b0, 4'd0);
        send_beat(ACT_SPEC, CH_A, 1'b0, 4'd0);
        send_beat(ACT_SPEC, 8'hFF, 1'b1, 4'd0);
        send_beat(ACT_KEY, CH_A, 1'b0, 4'd0);
        send_beat(ACT_KEY, 8'hFF, 1'b1, 4'd0);
        send_beat(ACT_KEY, 8'h00, 1'b1, 4'd0);
        send_beat(ACT_KEY, 8'h00, 1'b0, 4'd0);
        send_beat(ACT_KEY, CH_A, 1'b0, 4'd0);
        send_beat(ACT_KEY, CH_B, 1'b1, 4'd0);
    endtask

    task automatic test_prefix_during_key();
        send_beat(ACT_KEY, CH_A, 1'b0, 4'd0);
        send_beat(ACT_SPEC, CH_A, 1'b1, 4'd0);
        send_beat(ACT_KEY, CH_B, 1'b1, 4'd0);
        send_beat(ACT_KEY, CH_A, 1'b1, 4'd0);
    endtask

    task automatic test_read_and_clear();
        send_beat(ACT_READ, 8'h00, 1'b0, 4'd0);
        send_beat(ACT_READ, 8'h00, 1'b0, 4'd1);
        send_beat(ACT_READ, 8'h00, 1'b0, 4'd2);
        send_beat(ACT_READ, 8'h00, 1'b0, 4'd15);
        send_beat(ACT_CLEAR, 8'hFF, 1'b1, 4'd15);
        send_beat(ACT_READ, 8'h00, 1'b0, 4'd0);
        send_beat(ACT_KEY, CH_A, 1'b1, 4'd0);
        wait_idle();
    endtask

    // The receiver holds off long enough for the matcher to fill and stall its input.
    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= ~hold_req;
        for (i = 0; i < 20; i++) begin
            if (i % 2 == 0) send_beat(ACT_READ, 8'h00, 1'b0, INDEX_W'($urandom_range(15)));
            else            send_beat(ACT_KEY, pick_byte(), 1'b1, INDEX_W'($urandom_range(15)));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct, logic dflt);
        int target;
        int sel;
        int n;
        int p;
        int i;
        int j;
        logic [BYTE_W-1:0] b;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_default(dflt);
        target = items_sent + count;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            stream.delete();
            if (sel < 25) begin
                for (i = 0; i < $urandom_range(1, 3); i++) begin
                    if (i > 0) stream.push_back(SEP_BYTE);
                    p = $urandom_range(99);
                    if (p < 3)      n = 0;
                    else if (p < 7) n = $urandom_range(63, 67);
                    else            n = $urandom_range(1, 4);
                    for (j = 0; j < n; j++) begin
                        b = pick_byte();
                        stream.push_back((b == SEP_BYTE) ? CH_C : b);
                    end
                end
                if (stream.size() == 0 || stream[$] == SEP_BYTE || $urandom_range(1) == 1)
                    stream.push_back(SEP_BYTE);
                send_stream(ACT_SPEC);
            end else if (sel < 75) begin
                if (tbl_count > 0 && $urandom_range(99) < 60) begin
                    p = $urandom_range(tbl_count - 1);
                    n = tbl_len[p];
                    if ($urandom_range(4) == 0) n = $urandom_range(1, n);
                    for (j = 0; j < n; j++) stream.push_back(tbl_bytes[p][j]);
                    n = $urandom_range(0, 2);
                end else if ($urandom_range(99) < 5) begin
                    n = $urandom_range(60, 70);
                end else begin
                    n = $urandom_range(1, 6);
                end
                for (j = 0; j < n; j++) stream.push_back(pick_byte());
                send_stream(ACT_KEY);
            end else if (sel < 90) begin
                send_beat(ACT_READ, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                          INDEX_W'($urandom_range(1) ? $urandom_range(15)
                                   : $urandom_range((tbl_count > 0) ? tbl_count - 1 : 0)));
            end else if (sel < 93) begin
                send_beat(ACT_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                          INDEX_W'($urandom_range(15)));
            end else begin
                send_beat($urandom_range(1) ? ACT_KEY : ACT_SPEC, BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)), INDEX_W'($urandom_range(15)));
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 1'b0;
        in_if.valid         = 1'b0;
        in_if.action        = ACT_SPEC;
        in_if.data_byte     = '0;
        in_if.last          = 1'b0;
        in_if.pattern_index = '0;
        out_if.ready        = 1'b0;
        hold_req            = 1'b0;
        hold_seen           = 1'b0;
        hold_left           = 0;
        error_count         = 0;
        items_sent          = 0;
        cycle_count         = 0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        default_found       = 1'b0;
        clear_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table_default();
        test_load_and_match();
        test_prefix_during_key();
        test_read_and_clear();
        test_backpressure();
        test_random_traffic(450, 0, 0, 1'b1);
        test_random_traffic(450, 59, 0, 1'b0);
        test_random_traffic(450, 0, 59, 1'b1);
        test_random_traffic(450, 6, 6, 1'($urandom_range(1)));

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> multi_prefix_key_matcher.f
hw/rtl/mpkm_pkg.sv
hw/rtl/mpkm_if.sv
hw/rtl/mpkm_ram.sv
hw/rtl/multi_prefix_key_matcher.sv
hw/rtl/mpkm_checker.sv
tb/sv/multi_prefix_key_matcher_tb.sv
